@@ rtl/numeric_token_recognizer_core_assert.svh @@
// Assertion macros used by the checker file of the numeric token recognizer.
`ifndef NUMERIC_TOKEN_RECOGNIZER_CORE_ASSERT_SVH
`define NUMERIC_TOKEN_RECOGNIZER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define NTR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("numeric token recognizer: assertion failed");

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define NTR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("numeric token recognizer: assertion failed");

`endif

@@ rtl/ntr_pkg.sv @@
// Package with the shared types and character constants of the numeric token recognizer.
`timescale 1ns / 1ps

package ntr_pkg;

	// Character codes used by the grammar.
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LO_E  = 8'h65;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_LO_D  = 8'h64;
	localparam logic [7:0] CH_UP_D  = 8'h44;

	// Scan phase of the token grammar.
	typedef enum logic [3:0] {
		PH_WS    = 4'd0,
		PH_SIGN  = 4'd1,
		PH_IDIG  = 4'd2,
		PH_FRAC  = 4'd3,
		PH_EXP   = 4'd4,
		PH_ESIGN = 4'd5,
		PH_EDIG  = 4'd6,
		PH_DEAD  = 4'd7
	} phase_t;

	// Classification of one character.
	typedef struct packed {
		logic       is_ws;
		logic       is_dig;
		logic       is_sign;
		logic       is_minus;
		logic       is_dot;
		logic       is_exp;
		logic [3:0] digit;
	} char_class_t;

	// Control from the phase tracker to the value accumulator.
	typedef struct packed {
		logic       add;
		logic       clear;
		logic [3:0] digit;
	} acc_ctrl_t;

endpackage

@@ rtl/ntr_if.sv @@
// Valid/ready channel interfaces for the character and result transactions.
`timescale 1ns / 1ps

interface ntr_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last_char;

	modport source(output valid, output character, output last_char, input ready);
	modport sink(input valid, input character, input last_char, output ready);
endinterface

interface ntr_result_if;
	logic               valid;
	logic               ready;
	logic               int_valid;
	logic               float_valid;
	logic signed [31:0] int_value;
	logic               int_overflow;

	modport source(output valid, output int_valid, output float_valid, output int_value,
		output int_overflow, input ready);
	modport sink(input valid, input int_valid, input float_valid, input int_value,
		input int_overflow, output ready);
endinterface

@@ rtl/ntr_char_class.sv @@
// Character classifier: whitespace, digit, sign, dot and exponent letters.
`timescale 1ns / 1ps

module ntr_char_class (
	input  logic [7:0]          character,
	output ntr_pkg::char_class_t cls
);

	// Decode the byte against the character sets of the grammar.
	always_comb begin
		cls          = '0;
		cls.is_ws    = character inside {ntr_pkg::CH_SPACE, [ntr_pkg::CH_TAB:ntr_pkg::CH_CR]};
		cls.is_dig   = character inside {[ntr_pkg::CH_ZERO:ntr_pkg::CH_NINE]};
		cls.is_sign  = character inside {ntr_pkg::CH_PLUS, ntr_pkg::CH_MINUS};
		cls.is_minus = (character == ntr_pkg::CH_MINUS);
		cls.is_dot   = (character == ntr_pkg::CH_DOT);
		cls.is_exp   = character inside {ntr_pkg::CH_LO_E, ntr_pkg::CH_UP_E,
			ntr_pkg::CH_LO_D, ntr_pkg::CH_UP_D};
		cls.digit    = 4'(character - ntr_pkg::CH_ZERO);
	end

endmodule

@@ rtl/ntr_phase_tracker.sv @@
// Grammar phase register and its next-phase logic, with the sign flag.
`timescale 1ns / 1ps

module ntr_phase_tracker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 last,
	input  ntr_pkg::char_class_t cls,
	output ntr_pkg::phase_t      phase_next,
	output logic                 neg_next,
	output ntr_pkg::acc_ctrl_t   acc
);

	ntr_pkg::phase_t phase_q;
	logic            neg_q;
	logic            int_part;

	// Next phase for the current character; whitespace phase falls into the sign rules.
	always_comb begin
		phase_next = ntr_pkg::PH_DEAD;
		neg_next   = neg_q;
		int_part   = 1'b0;
		case (phase_q)
			ntr_pkg::PH_WS, ntr_pkg::PH_SIGN, ntr_pkg::PH_IDIG: begin
				if (phase_q == ntr_pkg::PH_WS && cls.is_ws) begin
					phase_next = ntr_pkg::PH_WS;
				end else if (phase_q == ntr_pkg::PH_WS && cls.is_sign) begin
					phase_next = ntr_pkg::PH_SIGN;
					neg_next   = cls.is_minus;
				end else if (cls.is_dig) begin
					phase_next = ntr_pkg::PH_IDIG;
					int_part   = 1'b1;
				end else if (cls.is_dot) begin
					phase_next = ntr_pkg::PH_FRAC;
				end else if (cls.is_exp) begin
					phase_next = ntr_pkg::PH_EXP;
				end
			end
			ntr_pkg::PH_FRAC: begin
				if (cls.is_dig) begin
					phase_next = ntr_pkg::PH_FRAC;
				end else if (cls.is_exp) begin
					phase_next = ntr_pkg::PH_EXP;
				end
			end
			ntr_pkg::PH_EXP: begin
				if (cls.is_sign) begin
					phase_next = ntr_pkg::PH_ESIGN;
				end else if (cls.is_dig) begin
					phase_next = ntr_pkg::PH_EDIG;
				end
			end
			ntr_pkg::PH_ESIGN, ntr_pkg::PH_EDIG: begin
				if (cls.is_dig) begin
					phase_next = ntr_pkg::PH_EDIG;
				end
			end
			default: begin
				phase_next = ntr_pkg::PH_DEAD;
			end
		endcase
	end

	// Accumulator control: add digits of the integer part, clear after the last one.
	always_comb begin
		acc.add   = step && int_part;
		acc.clear = step && last;
		acc.digit = cls.digit;
	end

	// Phase and sign registers return to reset after the final character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ntr_pkg::PH_WS;
			neg_q   <= 1'b0;
		end else if (step) begin
			if (last) begin
				phase_q <= ntr_pkg::PH_WS;
				neg_q   <= 1'b0;
			end else begin
				phase_q <= phase_next;
				neg_q   <= neg_next;
			end
		end
	end

endmodule

@@ rtl/ntr_value_acc.sv @@
// Saturating decimal accumulator for the magnitude of the leading integer.
`timescale 1ns / 1ps

module ntr_value_acc #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ntr_pkg::acc_ctrl_t     acc,
	output logic [VALUE_WIDTH-1:0] mag_next,
	output logic                   sat_next
);

	localparam int PW = VALUE_WIDTH + 4;
	localparam logic [PW-1:0] LIM = PW'(1) << (VALUE_WIDTH - 1);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   sat_q;
	logic [PW-1:0]          mag_ext;
	logic [PW-1:0]          prod;

	// Times ten plus the digit; exceeding the limit saturates to the limit.
	always_comb begin
		mag_ext  = PW'(mag_q);
		prod     = (mag_ext << 3) + (mag_ext << 1) + PW'(acc.digit);
		mag_next = mag_q;
		sat_next = sat_q;
		if (acc.add && !sat_q) begin
			if (prod > LIM) begin
				sat_next = 1'b1;
				mag_next = VALUE_WIDTH'(LIM);
			end else begin
				mag_next = prod[VALUE_WIDTH-1:0];
			end
		end
	end

	// Magnitude and saturation registers, cleared at the end of a token.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= '0;
			sat_q <= 1'b0;
		end else if (acc.clear) begin
			mag_q <= '0;
			sat_q <= 1'b0;
		end else begin
			mag_q <= mag_next;
			sat_q <= sat_next;
		end
	end

endmodule

@@ rtl/numeric_token_recognizer_core.sv @@
// Top level of the numeric token recognizer: input stage, scan logic and result register.
//
//   Channel   Role  Transaction
//   chars     sink  one token byte with its last_char flag
//   results   src   validity flags, saturated integer value and overflow of one token
//
// One character is taken every cycle unless stalled; the phase, sign and magnitude
// registers close their update loop combinationally. A token's result is registered
// behind the input stage. arst_n clears the token state and both valid flags. While a
// result waits on results.ready, characters that are not a token's last keep flowing;
// a last character waits in the input stage until the result register frees.
`timescale 1ns / 1ps

module numeric_token_recognizer_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	ntr_char_if.sink            chars,
	ntr_result_if.source        results
);

	localparam logic [VALUE_WIDTH-1:0] MAG_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

	logic                   valid_s1;
	logic [7:0]             char_s1;
	logic                   last_s1;
	logic                   out_free;
	logic                   step;
	ntr_pkg::char_class_t   cls;
	ntr_pkg::phase_t        phase_next;
	logic                   neg_next;
	ntr_pkg::acc_ctrl_t     acc;
	logic [VALUE_WIDTH-1:0] mag_next;
	logic                   sat_next;
	logic                   pos_clamp;
	logic [VALUE_WIDTH-1:0] mag_clamped;
	logic [31:0]            mag32;
	logic                   res_valid_q;
	logic                   int_valid_q;
	logic                   float_valid_q;
	logic signed [31:0]     int_value_q;
	logic                   int_overflow_q;

	// Handshake: the staged character proceeds unless it needs a busy result register.
	assign out_free    = !res_valid_q || results.ready;
	assign step        = valid_s1 && (!last_s1 || out_free);
	assign chars.ready = !valid_s1 || step;

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.character;
			last_s1 <= chars.last_char;
		end
	end

	ntr_char_class u_class (
		.character(char_s1),
		.cls      (cls)
	);

	ntr_phase_tracker u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.last      (last_s1),
		.cls       (cls),
		.phase_next(phase_next),
		.neg_next  (neg_next),
		.acc       (acc)
	);

	ntr_value_acc #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.mag_next(mag_next),
		.sat_next(sat_next)
	);

	// A positive value at the limit is clamped one below it; the sign is applied in 32 bits.
	assign pos_clamp   = !neg_next && mag_next[VALUE_WIDTH-1];
	assign mag_clamped = pos_clamp ? MAG_MAX : mag_next;
	assign mag32       = 32'(mag_clamped);

	// Result register, loaded when a token's last character is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			int_valid_q    <= phase_next inside {ntr_pkg::PH_WS, ntr_pkg::PH_SIGN,
				ntr_pkg::PH_IDIG};
			float_valid_q  <= (phase_next != ntr_pkg::PH_DEAD);
			int_value_q    <= neg_next ? 32'(32'd0 - mag32) : mag32;
			int_overflow_q <= sat_next || pos_clamp;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.int_valid    = int_valid_q;
	assign results.float_valid  = float_valid_q;
	assign results.int_value    = int_value_q;
	assign results.int_overflow = int_overflow_q;

endmodule

@@ rtl/ntr_checker.sv @@
// Port-level checker for the numeric token recognizer and its bind to the top level.
`timescale 1ns / 1ps
`include "numeric_token_recognizer_core_assert.svh"

module ntr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               chars_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic               int_valid,
	input logic               float_valid,
	input logic signed [31:0] int_value,
	input logic               int_overflow
);

	// A stalled result keeps its valid and its payload.
	`NTR_ASSERT_NEXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(int_valid) && $stable(float_valid) && $stable(int_value) && $stable(int_overflow))

	// Every token of the integer form also matches the float form.
	`NTR_ASSERT_NOW(a_int_implies_float, res_valid && int_valid, float_valid)

	// Input back-pressure only arises from a result that is waiting to be taken.
	`NTR_ASSERT_NOW(a_stall_source, !chars_ready, res_valid && !res_ready)

endmodule

bind numeric_token_recognizer_core ntr_checker u_ntr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.chars_ready (chars.ready),
	.res_valid   (results.valid),
	.res_ready   (results.ready),
	.int_valid   (results.int_valid),
	.float_valid (results.float_valid),
	.int_value   (results.int_value),
	.int_overflow(results.int_overflow)
);

@@ bench/numeric_token_recognizer_core_tb.sv @@
// Self-checking testbench for the numeric token recognizer: token streams in, verdicts out.
`timescale 1ns / 1ps

module numeric_token_recognizer_core_tb;

	localparam int VALUE_WIDTH = 32;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_CHARS = 450;
	localparam int QUIET_TAIL = 80;
	localparam int LONG_HOLD_CYCLES = 400;

	// One character transaction and one token verdict.
	typedef struct {
		logic [7:0] character;
		logic       last_char;
	} char_item_t;

	typedef struct {
		logic               int_valid;
		logic               float_valid;
		logic signed [31:0] int_value;
		logic               int_overflow;
	} token_verdict_t;

	logic clk;
	logic arst_n;

	ntr_char_if   chars_if();
	ntr_result_if results_if();

	numeric_token_recognizer_core #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.results(results_if)
	);

	char_item_t     pending_chars[$];
	token_verdict_t expected_verdicts[$];

	// Scanner state mirrored from the block's grammar.
	ntr_pkg::phase_t scan_ph;
	logic            scan_neg;
	logic [63:0]     scan_mag;
	logic            scan_sat;

	int mismatch_count = 0;
	int chars_sent = 0;
	int verdicts_checked = 0;
	int ints_seen = 0;
	int floats_seen = 0;
	int saturations_seen = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int recv_gap = 0;
	logic long_hold = 1'b0;

	// The clock runs with a 4 ns period.
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Return the scanner to its state at the start of a token.
	function automatic void clear_scan();
		scan_ph  = ntr_pkg::PH_WS;
		scan_neg = 1'b0;
		scan_mag = '0;
		scan_sat = 1'b0;
	endfunction

	// Advance the scanner by one character; the final character yields a verdict.
	function automatic void scan_token_char(input logic [7:0] c, input logic last);
		logic           ws, dig, sgn, expc;
		logic [63:0]    lim, dval, m;
		logic           ovf;
		token_verdict_t v;
		ws   = (c == ntr_pkg::CH_SPACE) || (c >= ntr_pkg::CH_TAB && c <= ntr_pkg::CH_CR);
		dig  = (c >= ntr_pkg::CH_ZERO) && (c <= ntr_pkg::CH_NINE);
		sgn  = (c == ntr_pkg::CH_PLUS) || (c == ntr_pkg::CH_MINUS);
		expc = (c == ntr_pkg::CH_LO_E) || (c == ntr_pkg::CH_UP_E) ||
			(c == ntr_pkg::CH_LO_D) || (c == ntr_pkg::CH_UP_D);
		lim  = 64'd1 << (VALUE_WIDTH - 1);
		dval = 64'(c[3:0]);
		case (scan_ph)
			ntr_pkg::PH_WS, ntr_pkg::PH_SIGN, ntr_pkg::PH_IDIG: begin
				if (scan_ph == ntr_pkg::PH_WS && ws) begin
					scan_ph = ntr_pkg::PH_WS;
				end else if (scan_ph == ntr_pkg::PH_WS && sgn) begin
					scan_neg = (c == ntr_pkg::CH_MINUS);
					scan_ph  = ntr_pkg::PH_SIGN;
				end else if (dig) begin
					// Saturate once the magnitude would pass the negative limit.
					if (!scan_sat) begin
						if (scan_mag > (lim - dval) / 10) begin
							scan_sat = 1'b1;
							scan_mag = lim;
						end else begin
							scan_mag = scan_mag * 10 + dval;
						end
					end
					scan_ph = ntr_pkg::PH_IDIG;
				end else if (c == ntr_pkg::CH_DOT) begin
					scan_ph = ntr_pkg::PH_FRAC;
				end else if (expc) begin
					scan_ph = ntr_pkg::PH_EXP;
				end else begin
					scan_ph = ntr_pkg::PH_DEAD;
				end
			end
			ntr_pkg::PH_FRAC: begin
				if (dig) scan_ph = ntr_pkg::PH_FRAC;
				else if (expc) scan_ph = ntr_pkg::PH_EXP;
				else scan_ph = ntr_pkg::PH_DEAD;
			end
			ntr_pkg::PH_EXP: begin
				if (sgn) scan_ph = ntr_pkg::PH_ESIGN;
				else if (dig) scan_ph = ntr_pkg::PH_EDIG;
				else scan_ph = ntr_pkg::PH_DEAD;
			end
			ntr_pkg::PH_ESIGN, ntr_pkg::PH_EDIG: begin
				if (dig) scan_ph = ntr_pkg::PH_EDIG;
				else scan_ph = ntr_pkg::PH_DEAD;
			end
			default: begin
				scan_ph = ntr_pkg::PH_DEAD;
			end
		endcase
		if (last) begin
			// A positive value above the top of the range is clipped as well.
			m   = scan_mag;
			ovf = scan_sat;
			if (!scan_neg && m > lim - 1) begin
				m   = lim - 1;
				ovf = 1'b1;
			end
			if (scan_neg) m = -m;
			v.int_valid    = (scan_ph <= ntr_pkg::PH_IDIG);
			v.float_valid  = (scan_ph != ntr_pkg::PH_DEAD);
			v.int_value    = m[31:0];
			v.int_overflow = ovf;
			expected_verdicts.push_back(v);
			clear_scan();
		end
	endfunction

	// Queue the bytes of one token, flagging the final one.
	function automatic void queue_token(input logic [7:0] bytes[$]);
		char_item_t it;
		foreach (bytes[i]) begin
			it.character = bytes[i];
			it.last_char = (i == bytes.size() - 1);
			pending_chars.push_back(it);
		end
	endfunction

	// Build a token that follows the float grammar, with random content.
	function automatic void build_number(ref logic [7:0] tok[$]);
		longint edge_vals[6] = '{64'd2147483647, 64'd2147483648, 64'd2147483649,
			64'd214748364, 64'd9999999999, 64'd21474836470};
		string  s;
		int     n;
		repeat ($urandom_range(0, 2)) begin
			if ($urandom_range(0, 2) == 0) tok.push_back(ntr_pkg::CH_SPACE);
			else tok.push_back(8'($urandom_range(9, 13)));
		end
		if ($urandom_range(0, 1)) begin
			tok.push_back($urandom_range(0, 1) ? ntr_pkg::CH_MINUS : ntr_pkg::CH_PLUS);
		end
		if ($urandom_range(0, 4) == 0) begin
			// Values around the signed 32-bit limits, sometimes with leading zeros.
			s = $sformatf("%0d", edge_vals[$urandom_range(0, 5)]);
			if ($urandom_range(0, 3) == 0) s = {"000", s};
			for (int i = 0; i < s.len(); i++) tok.push_back(8'(s[i]));
		end else begin
			n = $urandom_range(0, 12);
			repeat (n) tok.push_back(8'($urandom_range(ntr_pkg::CH_ZERO, ntr_pkg::CH_NINE)));
		end
		if ($urandom_range(0, 9) < 4) begin
			tok.push_back(ntr_pkg::CH_DOT);
			repeat ($urandom_range(0, 3)) begin
				tok.push_back(8'($urandom_range(ntr_pkg::CH_ZERO, ntr_pkg::CH_NINE)));
			end
		end
		if ($urandom_range(0, 9) < 3) begin
			case ($urandom_range(0, 3))
				0: tok.push_back(ntr_pkg::CH_LO_E);
				1: tok.push_back(ntr_pkg::CH_UP_E);
				2: tok.push_back(ntr_pkg::CH_LO_D);
				default: tok.push_back(ntr_pkg::CH_UP_D);
			endcase
			if ($urandom_range(0, 1)) begin
				tok.push_back($urandom_range(0, 1) ? ntr_pkg::CH_MINUS : ntr_pkg::CH_PLUS);
			end
			repeat ($urandom_range(0, 3)) begin
				tok.push_back(8'($urandom_range(ntr_pkg::CH_ZERO, ntr_pkg::CH_NINE)));
			end
		end
		if (tok.size() == 0) begin
			tok.push_back(8'($urandom_range(ntr_pkg::CH_ZERO, ntr_pkg::CH_NINE)));
		end
	endfunction

	// Fill the stimulus queue, then run reset and wait for the traffic to drain.
	initial begin
		logic [7:0] tok[$];
		int         random_chars;
		int         kind;
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.character = '0;
		chars_if.last_char = 1'b0;
		results_if.ready = 1'b0;
		clear_scan();

		// Directed tokens: odd bytes, lone signs, whitespace only, bare exponents.
		queue_token('{8'h00});
		queue_token('{8'hFF});
		queue_token('{ntr_pkg::CH_MINUS});
		queue_token('{ntr_pkg::CH_TAB});
		queue_token('{ntr_pkg::CH_UP_D, ntr_pkg::CH_NINE});
		queue_token('{8'h35, ntr_pkg::CH_LO_E, ntr_pkg::CH_PLUS});
		queue_token('{ntr_pkg::CH_ZERO, 8'h78});
		queue_token('{ntr_pkg::CH_CR, ntr_pkg::CH_MINUS, ntr_pkg::CH_NINE});
		queue_token('{ntr_pkg::CH_DOT});
		queue_token('{8'h37, ntr_pkg::CH_DOT});
		queue_token('{ntr_pkg::CH_UP_E});
		queue_token('{ntr_pkg::CH_PLUS, ntr_pkg::CH_DOT});
		queue_token('{8'h34, 8'h80});
		queue_token('{ntr_pkg::CH_MINUS, ntr_pkg::CH_MINUS});

		// Random tokens: mostly well formed, some corrupted, some pure noise.
		random_chars = 0;
		while (random_chars < RANDOM_CHARS) begin
			tok.delete();
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				build_number(tok);
			end else if (kind < 9) begin
				build_number(tok);
				tok[$urandom_range(0, tok.size() - 1)] = 8'($urandom_range(0, 255));
			end else begin
				repeat ($urandom_range(1, 6)) tok.push_back(8'($urandom_range(0, 255)));
			end
			queue_token(tok);
			random_chars += tok.size();
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every character is taken and every verdict has come back.
		while (pending_chars.size() != 0 || chars_if.valid) @(negedge clk);
		while (expected_verdicts.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("Covered %0d characters in %0d tokens: %0d valid integers, %0d valid floats,",
			chars_sent, verdicts_checked, ints_seen, floats_seen);
		$display("%0d saturated values, one long output stall and random idling on both sides.",
			saturations_seen);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Character driver: predicts each accepted transaction and offers the next one.
	always @(posedge clk) begin : drive_chars
		char_item_t nxt;
		logic       may_idle;
		if (!arst_n) begin
			chars_if.valid     <= 1'b0;
			chars_if.character <= '0;
			chars_if.last_char <= 1'b0;
		end else begin
			if (chars_if.valid && chars_if.ready) begin
				scan_token_char(chars_if.character, chars_if.last_char);
				chars_sent++;
			end
			may_idle = pending_chars.size() > QUIET_TAIL;
			if (!chars_if.valid || chars_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					chars_if.valid <= 1'b0;
				end else if (may_idle && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(1, 10) - 1;
					chars_if.valid <= 1'b0;
				end else if (pending_chars.size() != 0) begin
					nxt = pending_chars.pop_front();
					chars_if.valid     <= 1'b1;
					chars_if.character <= nxt.character;
					chars_if.last_char <= nxt.last_char;
				end else begin
					chars_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each verdict with the oldest prediction.
	always @(posedge clk) begin : watch_results
		token_verdict_t exp_v;
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			if (results_if.valid && results_if.ready) begin
				if (expected_verdicts.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result transaction, int_value %0d", $time,
						results_if.int_value);
				end else begin
					exp_v = expected_verdicts.pop_front();
					if (results_if.int_valid !== exp_v.int_valid) begin
						mismatch_count++;
						$display("%0t: int_valid expected %0b actual %0b", $time,
							exp_v.int_valid, results_if.int_valid);
					end
					if (results_if.float_valid !== exp_v.float_valid) begin
						mismatch_count++;
						$display("%0t: float_valid expected %0b actual %0b", $time,
							exp_v.float_valid, results_if.float_valid);
					end
					if (results_if.int_value !== exp_v.int_value) begin
						mismatch_count++;
						$display("%0t: int_value expected %0d actual %0d", $time,
							exp_v.int_value, results_if.int_value);
					end
					if (results_if.int_overflow !== exp_v.int_overflow) begin
						mismatch_count++;
						$display("%0t: int_overflow expected %0b actual %0b", $time,
							exp_v.int_overflow, results_if.int_overflow);
					end
					ints_seen += exp_v.int_valid;
					floats_seen += exp_v.float_valid;
					saturations_seen += exp_v.int_overflow;
				end
				verdicts_checked++;
			end
			if (long_hold) begin
				results_if.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				results_if.ready <= 1'b0;
			end else if (pending_chars.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(1, 10) - 1;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	// One long output stall early on, so the input side backs up behind it.
	initial begin
		while (verdicts_checked < 6) @(negedge clk);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run stopped at the cycle limit with %0d verdicts outstanding",
				$time, expected_verdicts.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
